>>> sv/srtm_pkg.sv
// ----------------------------------------------------------------------------
// srtm_pkg
// Shared types, codes and a helper function of the sparse radix trie map.
// ----------------------------------------------------------------------------
package srtm_pkg;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_POOL   = 2'd2;
  localparam logic [1:0] ST_CONFIG = 2'd3;

  localparam logic [2:0] REG_KEY_WIDTH  = 3'd0;
  localparam logic [2:0] REG_ITEM_LOG   = 3'd1;
  localparam logic [2:0] REG_NODE_BITS  = 3'd2;
  localparam logic [2:0] REG_BLOCK_BITS = 3'd3;
  localparam logic [2:0] REG_EMPTY      = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LEVEL,
    S_PWAIT,
    S_PZERO,
    S_PLINK,
    S_DFILL,
    S_DLINK,
    S_DRD,
    S_DWAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [6:0]  key_width;
    logic [2:0]  item_log;
    logic [3:0]  node_bits;
    logic [3:0]  block_bits;
    logic [63:0] empty_m;
    logic [63:0] fill;
    logic        valid;
    logic        clear;
  } cfg_t;

  function automatic logic [63:0] low_mask(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) m = '1;
    else m = (64'd1 << n[5:0]) - 64'd1;
    return m;
  endfunction

endpackage

>>> sv/srtm_in_if.sv
// ----------------------------------------------------------------------------
// srtm_in_if
// Request channel: get or set of one key.
// ----------------------------------------------------------------------------
interface srtm_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] lookup_key;
  logic [63:0] store_value;

  modport source (output valid, mode, lookup_key, store_value, input ready);
  modport sink (input valid, mode, lookup_key, store_value, output ready);
endinterface

>>> sv/srtm_out_if.sv
// ----------------------------------------------------------------------------
// srtm_out_if
// Result channel: read value and status.
// ----------------------------------------------------------------------------
interface srtm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic [1:0]  status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

>>> sv/srtm_cfg_if.sv
// ----------------------------------------------------------------------------
// srtm_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface srtm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/sparse_radix_trie_map_core.sv
// ----------------------------------------------------------------------------
// sparse_radix_trie_map_core
// Sparse key-to-value map held in a fixed-depth radix trie.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  in_ch    in   mode, lookup_key, store_value
//  out_ch   out  read_value, status
//  cfg_ch   in   index, data (always ready)
//
// one item at a time: setup and result, a pointer store read per pointer
// level, a data word read, plus a store sweep over the words of each new
// node and of each new data block
// reset and every register write empty the map through the free counts
// a stalled result holds in the output register; the next word is taken meanwhile
module sparse_radix_trie_map_core #(
  parameter int POINTER_WORDS  = 4096,
  parameter int DATA_WORDS     = 16384,
  parameter int MAX_NODE_BITS  = 8,
  parameter int MAX_BLOCK_BITS = 12
) (
  input logic        clk,
  input logic        rst_n,
  srtm_in_if.sink    in_ch,
  srtm_out_if.source out_ch,
  srtm_cfg_if.sink   cfg_ch
);

  srtm_pkg::cfg_t cfg;

  assign cfg_ch.ready = 1'b1;

  srtm_cfg #(
    .MAX_NODE_BITS (MAX_NODE_BITS),
    .MAX_BLOCK_BITS(MAX_BLOCK_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(cfg_ch.valid),
    .wr_index(cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  srtm_walk #(
    .POINTER_WORDS (POINTER_WORDS),
    .DATA_WORDS    (DATA_WORDS),
    .MAX_NODE_BITS (MAX_NODE_BITS),
    .MAX_BLOCK_BITS(MAX_BLOCK_BITS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_key    (in_ch.lookup_key),
    .in_value  (in_ch.store_value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.read_value),
    .out_status(out_ch.status)
  );

endmodule

>>> sv/srtm_cfg.sv
// ----------------------------------------------------------------------------
// srtm_cfg
// Configuration registers, validity check and derived empty and fill words.
// ----------------------------------------------------------------------------
module srtm_cfg #(
  parameter int MAX_NODE_BITS  = 8,
  parameter int MAX_BLOCK_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  input  logic [2:0]         wr_index,
  input  logic [63:0]        wr_data,
  output srtm_pkg::cfg_t     cfg
);

  logic [6:0]  key_width_r;
  logic [2:0]  item_log_r;
  logic [3:0]  node_bits_r;
  logic [3:0]  block_bits_r;
  logic [63:0] empty_r;
  logic [63:0] empty_m;
  logic [63:0] fill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_width_r  <= 7'd32;
      item_log_r   <= 3'd6;
      node_bits_r  <= 4'd8;
      block_bits_r <= 4'd8;
      empty_r      <= '0;
    end else if (wr_valid) begin
      case (wr_index)
        srtm_pkg::REG_KEY_WIDTH:  key_width_r  <= wr_data[6:0];
        srtm_pkg::REG_ITEM_LOG:   item_log_r   <= wr_data[2:0];
        srtm_pkg::REG_NODE_BITS:  node_bits_r  <= wr_data[3:0];
        srtm_pkg::REG_BLOCK_BITS: block_bits_r <= wr_data[3:0];
        srtm_pkg::REG_EMPTY:      empty_r      <= wr_data;
        default: ;
      endcase
    end
  end

  // empty value masked to the item and repeated over the word
  always_comb begin
    case (item_log_r)
      3'd0: begin empty_m = {63'd0, empty_r[0]};    fill = {64{empty_r[0]}};   end
      3'd1: begin empty_m = {62'd0, empty_r[1:0]};  fill = {32{empty_r[1:0]}}; end
      3'd2: begin empty_m = {60'd0, empty_r[3:0]};  fill = {16{empty_r[3:0]}}; end
      3'd3: begin empty_m = {56'd0, empty_r[7:0]};  fill = {8{empty_r[7:0]}};  end
      3'd4: begin empty_m = {48'd0, empty_r[15:0]}; fill = {4{empty_r[15:0]}}; end
      3'd5: begin empty_m = {32'd0, empty_r[31:0]}; fill = {2{empty_r[31:0]}}; end
      default: begin empty_m = empty_r; fill = empty_r; end
    endcase
  end

  always_comb begin
    cfg.key_width  = key_width_r;
    cfg.item_log   = item_log_r;
    cfg.node_bits  = node_bits_r;
    cfg.block_bits = block_bits_r;
    cfg.empty_m    = empty_m;
    cfg.fill       = fill;
    cfg.valid      = (item_log_r <= 3'd6) && (key_width_r >= 7'd1) && (key_width_r <= 7'd64)
                     && (node_bits_r >= 4'd1) && (int'(node_bits_r) <= MAX_NODE_BITS)
                     && (block_bits_r >= 4'd1) && (int'(block_bits_r) <= MAX_BLOCK_BITS)
                     && ({3'd0, block_bits_r} <= key_width_r);
    cfg.clear      = wr_valid && (wr_index <= srtm_pkg::REG_EMPTY);
  end

endmodule

>>> sv/srtm_walk.sv
// ----------------------------------------------------------------------------
// srtm_walk
// Trie walk sequencer with the pointer store and the data store.
// ----------------------------------------------------------------------------
module srtm_walk #(
  parameter int POINTER_WORDS  = 4096,
  parameter int DATA_WORDS     = 16384,
  parameter int MAX_NODE_BITS  = 8,
  parameter int MAX_BLOCK_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srtm_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [63:0]       in_key,
  input  logic [63:0]       in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_value,
  output logic [1:0]        out_status
);

  localparam int PAW  = $clog2(POINTER_WORDS);
  localparam int PCW  = $clog2(POINTER_WORDS + 1);
  localparam int DAW  = $clog2(DATA_WORDS);
  localparam int DCW  = $clog2(DATA_WORDS + 1);
  localparam int LW   = (PCW > DCW) ? PCW : DCW;
  localparam int CNTW = ((MAX_NODE_BITS > MAX_BLOCK_BITS) ? MAX_NODE_BITS : MAX_BLOCK_BITS) + 1;
  localparam int PSW  = ((PCW > CNTW) ? PCW : CNTW) + 1;
  localparam int DSW  = ((LW > CNTW) ? LW : CNTW) + 1;

  logic [LW-1:0] pmem [POINTER_WORDS];
  logic [63:0]   dmem [DATA_WORDS];

  srtm_pkg::state_t state_r, state_nxt;
  logic           mode_r, mode_nxt;
  logic [63:0]    key_r, key_nxt;
  logic [63:0]    val_r, val_nxt;
  logic [6:0]     pos_r, pos_nxt;
  logic [LW-1:0]  link_r, link_nxt;
  logic [PAW-1:0] slot_r, slot_nxt;
  logic           at_root_r, at_root_nxt;
  logic [MAX_NODE_BITS-1:0] idx_r, idx_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] size_r, size_nxt;
  logic [PCW-1:0] pnf_r, pnf_nxt;
  logic [DCW-1:0] dnf_r, dnf_nxt;
  logic [LW-1:0]  root_r, root_nxt;
  logic [DAW-1:0] wpos_r, wpos_nxt;
  logic [63:0]    res_val_r, res_val_nxt;
  logic [1:0]     res_st_r, res_st_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [63:0]    out_value_r, out_value_nxt;
  logic [1:0]     out_status_r, out_status_nxt;

  logic           p_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [LW-1:0]  p_wdata, p_rdata_r;
  logic           d_we;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [63:0]    d_wdata, d_rdata_r;

  // per-level geometry
  logic [6:0]  rest, sh;
  logic        full_lvl, lvl_data, link_zero, range_bad, ppool_full, dpool_full, sweep_last;
  logic [3:0]  w;
  logic [63:0] kshift;
  logic [MAX_NODE_BITS-1:0] idx, idx_mask;
  logic [CNTW-1:0] psize, bwords;
  logic [4:0]  bsz;
  logic [2:0]  shift;
  logic [63:0] blk_bits;
  logic [DSW-1:0] wpos_sum;
  logic [DAW-1:0] wpos;
  logic [5:0]  offs;
  logic [63:0] item_mask;
  logic [PAW-1:0] slot_c;

  assign rest      = pos_r - {3'd0, cfg.block_bits};
  assign full_lvl  = rest > {3'd0, cfg.node_bits};
  assign lvl_data  = (rest == 7'd0);
  assign w         = full_lvl ? cfg.node_bits : rest[3:0];
  assign sh        = full_lvl ? (pos_r - {3'd0, cfg.node_bits}) : {3'd0, cfg.block_bits};
  assign kshift    = key_r >> sh[5:0];
  assign idx_mask  = MAX_NODE_BITS'((CNTW'(1) << w) - CNTW'(1));
  assign idx       = kshift[MAX_NODE_BITS-1:0] & idx_mask;
  assign psize     = CNTW'(1) << w;
  assign link_zero = (link_r == '0);
  assign range_bad = (key_r & ~srtm_pkg::low_mask(cfg.key_width)) != 64'd0;
  assign slot_c    = PAW'(PSW'(link_r) - PSW'(1) + PSW'(idx));

  assign bsz    = {1'b0, cfg.block_bits} + {2'd0, cfg.item_log};
  assign bwords = (bsz < 5'd6) ? CNTW'(1) : (CNTW'(1) << (bsz - 5'd6));
  assign ppool_full = (PSW'(pnf_r) + PSW'(psize)) > PSW'(POINTER_WORDS);
  assign dpool_full = (DSW'(dnf_r) + DSW'(bwords)) > DSW'(DATA_WORDS);
  assign sweep_last = (cnt_r == size_r - CNTW'(1));

  assign shift     = 3'd6 - cfg.item_log;
  assign blk_bits  = (key_r & srtm_pkg::low_mask({3'd0, cfg.block_bits})) >> shift;
  assign wpos_sum  = DSW'(link_r) - DSW'(1) + DSW'(blk_bits[MAX_BLOCK_BITS-1:0]);
  assign wpos      = (wpos_sum >= DSW'(DATA_WORDS)) ? DAW'(DATA_WORDS - 1) : DAW'(wpos_sum);
  assign offs      = 6'((key_r & srtm_pkg::low_mask({4'd0, shift})) << cfg.item_log);
  assign item_mask = srtm_pkg::low_mask(7'd1 << cfg.item_log) << offs;

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata_r <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    d_rdata_r <= dmem[d_raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srtm_pkg::S_IDLE:  if (in_valid) state_nxt = srtm_pkg::S_START;
      srtm_pkg::S_START: begin
        if (!cfg.valid || range_bad) state_nxt = srtm_pkg::S_EMIT;
        else state_nxt = srtm_pkg::S_LEVEL;
      end
      srtm_pkg::S_LEVEL: begin
        if (lvl_data) begin
          if (!link_zero) state_nxt = srtm_pkg::S_DRD;
          else if (!mode_r || dpool_full) state_nxt = srtm_pkg::S_EMIT;
          else state_nxt = srtm_pkg::S_DFILL;
        end else begin
          if (!link_zero) state_nxt = srtm_pkg::S_PWAIT;
          else if (!mode_r || ppool_full) state_nxt = srtm_pkg::S_EMIT;
          else state_nxt = srtm_pkg::S_PZERO;
        end
      end
      srtm_pkg::S_PWAIT: state_nxt = srtm_pkg::S_LEVEL;
      srtm_pkg::S_PZERO: if (sweep_last) state_nxt = srtm_pkg::S_PLINK;
      srtm_pkg::S_PLINK: state_nxt = srtm_pkg::S_LEVEL;
      srtm_pkg::S_DFILL: if (sweep_last) state_nxt = srtm_pkg::S_DLINK;
      srtm_pkg::S_DLINK: state_nxt = srtm_pkg::S_DRD;
      srtm_pkg::S_DRD:   state_nxt = srtm_pkg::S_DWAIT;
      srtm_pkg::S_DWAIT: state_nxt = srtm_pkg::S_EMIT;
      srtm_pkg::S_EMIT:  if (!out_valid_r || out_ready) state_nxt = srtm_pkg::S_IDLE;
      default: state_nxt = srtm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    pos_nxt      = pos_r;
    link_nxt     = link_r;
    slot_nxt     = slot_r;
    at_root_nxt  = at_root_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    size_nxt     = size_r;
    pnf_nxt      = pnf_r;
    dnf_nxt      = dnf_r;
    root_nxt     = root_r;
    wpos_nxt     = wpos_r;
    res_val_nxt  = res_val_r;
    res_st_nxt   = res_st_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    p_we    = 1'b0;
    p_waddr = PAW'(PSW'(pnf_r) + PSW'(cnt_r));
    p_wdata = '0;
    p_raddr = slot_c;
    d_we    = 1'b0;
    d_waddr = DAW'(DSW'(dnf_r) + DSW'(cnt_r));
    d_wdata = cfg.fill;
    d_raddr = wpos;
    case (state_r)
      srtm_pkg::S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          key_nxt  = in_key;
          val_nxt  = in_value;
        end
      end
      srtm_pkg::S_START: begin
        if (!cfg.valid) begin
          res_val_nxt = '0;
          res_st_nxt  = srtm_pkg::ST_CONFIG;
        end else if (range_bad) begin
          res_val_nxt = cfg.empty_m;
          res_st_nxt  = srtm_pkg::ST_RANGE;
        end else begin
          pos_nxt     = cfg.key_width;
          link_nxt    = root_r;
          at_root_nxt = 1'b1;
        end
      end
      srtm_pkg::S_LEVEL: begin
        res_val_nxt = mode_r ? 64'd0 : cfg.empty_m;
        res_st_nxt  = mode_r ? srtm_pkg::ST_POOL : srtm_pkg::ST_DONE;
        cnt_nxt     = '0;
        if (lvl_data) begin
          size_nxt = bwords;
        end else begin
          size_nxt = psize;
          idx_nxt  = idx;
          pos_nxt  = sh;
          if (!link_zero) begin
            slot_nxt    = slot_c;
            at_root_nxt = 1'b0;
          end
        end
      end
      srtm_pkg::S_PWAIT: link_nxt = p_rdata_r;
      srtm_pkg::S_PZERO: begin
        p_we    = 1'b1;
        cnt_nxt = cnt_r + CNTW'(1);
      end
      srtm_pkg::S_PLINK: begin
        // hook the new node into its parent slot or the root; its words are all null
        if (at_root_r) root_nxt = LW'(PSW'(pnf_r) + PSW'(1));
        else begin
          p_we    = 1'b1;
          p_waddr = slot_r;
          p_wdata = LW'(PSW'(pnf_r) + PSW'(1));
        end
        slot_nxt    = PAW'(PSW'(pnf_r) + PSW'(idx_r));
        at_root_nxt = 1'b0;
        pnf_nxt     = PCW'(PSW'(pnf_r) + PSW'(size_r));
        link_nxt    = '0;
      end
      srtm_pkg::S_DFILL: begin
        d_we    = 1'b1;
        cnt_nxt = cnt_r + CNTW'(1);
      end
      srtm_pkg::S_DLINK: begin
        if (at_root_r) root_nxt = LW'(DSW'(dnf_r) + DSW'(1));
        else begin
          p_we    = 1'b1;
          p_waddr = slot_r;
          p_wdata = LW'(DSW'(dnf_r) + DSW'(1));
        end
        link_nxt = LW'(DSW'(dnf_r) + DSW'(1));
        dnf_nxt  = DCW'(DSW'(dnf_r) + DSW'(size_r));
      end
      srtm_pkg::S_DRD: wpos_nxt = wpos;
      srtm_pkg::S_DWAIT: begin
        res_st_nxt = srtm_pkg::ST_DONE;
        if (mode_r) begin
          d_we        = 1'b1;
          d_waddr     = wpos_r;
          d_wdata     = (d_rdata_r & ~item_mask) | ((val_r << offs) & item_mask);
          res_val_nxt = '0;
        end else begin
          res_val_nxt = (d_rdata_r & item_mask) >> offs;
        end
      end
      srtm_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_val_r;
          out_status_nxt = res_st_r;
        end
      end
      default: ;
    endcase
    if (cfg.clear) begin
      pnf_nxt  = '0;
      dnf_nxt  = '0;
      root_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srtm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pnf_r       <= '0;
      dnf_r       <= '0;
      root_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pnf_r       <= pnf_nxt;
      dnf_r       <= dnf_nxt;
      root_r      <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    link_r       <= link_nxt;
    slot_r       <= slot_nxt;
    at_root_r    <= at_root_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    size_r       <= size_nxt;
    wpos_r       <= wpos_nxt;
    res_val_r    <= res_val_nxt;
    res_st_r     <= res_st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == srtm_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule
